@@ sv/frame_dirty_tile_detector_top_defines.svh @@
// Assertion macros of the frame dirty tile detector, used by the flag module.
`ifndef FRAME_DIRTY_TILE_DETECTOR_TOP_DEFINES_SVH
`define FRAME_DIRTY_TILE_DETECTOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while arst_n is low.
`define FDTD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and disabled while arst_n is low.
`define FDTD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/fdtd_pkg.sv @@
// Shared constants, types and helpers of the frame dirty tile detector.
package fdtd_pkg;

	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 512;
	localparam int PIXEL_BITS = 16;
	localparam int TILE_LIMIT = 64;

	localparam int PIX_W      = 16;
	localparam int CFG_DIM_W  = 10;
	localparam int CFG_TILE_W = 7;
	localparam int POS_W      = 9;
	localparam int IN_TILE_W  = 6;
	localparam int COUNT_W    = 19;
	localparam int COL_AW     = $clog2(MAX_WIDTH);
	localparam int ONES_W     = $clog2(MAX_WIDTH + 1);
	localparam int APB_AW     = 4;
	localparam int APB_DW     = 32;

	localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((33'd1 << PIXEL_BITS) - 33'd1);

	localparam logic [CFG_DIM_W-1:0]  FRAME_WIDTH_RST  = CFG_DIM_W'(480);
	localparam logic [CFG_DIM_W-1:0]  FRAME_HEIGHT_RST = CFG_DIM_W'(320);
	localparam logic [CFG_TILE_W-1:0] TILE_EDGE_RST    = CFG_TILE_W'(16);

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_TILE_EDGE    = 2'd2
	} cfg_reg_t;

	// Position decode for the pixel pair at the head of the input channel.
	typedef struct packed {
		logic              tx_end;
		logic              ty_end;
		logic              row_end;
		logic              col_end;
		logic              emit;
		logic              done;
		logic [POS_W-1:0]  tile_x;
		logic [POS_W-1:0]  tile_y;
		logic [COL_AW-1:0] col;
		logic [COL_AW-1:0] next_col;
	} pos_info_t;

	// Zero acts as one, anything above the limit acts as the limit.
	function automatic logic [CFG_DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v,
			input logic [CFG_DIM_W-1:0] hi);
		logic [CFG_DIM_W-1:0] r;
		if (v == '0) begin
			r = CFG_DIM_W'(1);
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [CFG_TILE_W-1:0] clamp_tile(input logic [CFG_TILE_W-1:0] v);
		logic [CFG_TILE_W-1:0] r;
		if (v == '0) begin
			r = CFG_TILE_W'(1);
		end else if (v > CFG_TILE_W'(TILE_LIMIT)) begin
			r = CFG_TILE_W'(TILE_LIMIT);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

@@ sv/fdtd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module fdtd_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/fdtd_pos.sv @@
// Raster position counters and tile boundary decode.
module fdtd_pos
	import fdtd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic [CFG_DIM_W-1:0]  frame_width,
	input  logic [CFG_DIM_W-1:0]  frame_height,
	input  logic [CFG_TILE_W-1:0] tile_edge,
	output pos_info_t             info
);

	logic [POS_W-1:0]      pixel_x_q, pixel_y_q;
	logic [IN_TILE_W-1:0]  in_tile_x_q, in_tile_y_q;
	logic [POS_W-1:0]      tile_x_q, tile_y_q;
	logic [CFG_DIM_W-1:0]  w_m1, h_m1;
	logic [CFG_TILE_W-1:0] ts_m1;

	assign w_m1  = clamp_dim(frame_width, CFG_DIM_W'(MAX_WIDTH)) - CFG_DIM_W'(1);
	assign h_m1  = clamp_dim(frame_height, CFG_DIM_W'(MAX_HEIGHT)) - CFG_DIM_W'(1);
	assign ts_m1 = clamp_tile(tile_edge) - CFG_TILE_W'(1);

	// Edges compare with "at or beyond" so a counter left large by a
	// reconfiguration wraps on the next pixel.
	always_comb begin
		info          = '0;
		info.row_end  = {1'b0, pixel_x_q} >= w_m1;
		info.col_end  = {1'b0, pixel_y_q} >= h_m1;
		info.tx_end   = info.row_end || ({1'b0, in_tile_x_q} >= ts_m1);
		info.ty_end   = info.col_end || ({1'b0, in_tile_y_q} >= ts_m1);
		info.emit     = info.tx_end && info.ty_end;
		info.done     = info.row_end && info.col_end;
		info.tile_x   = tile_x_q;
		info.tile_y   = tile_y_q;
		info.col      = COL_AW'(tile_x_q % MAX_WIDTH);
		info.next_col = info.row_end ? '0 : COL_AW'((tile_x_q + POS_W'(1)) % MAX_WIDTH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_x_q   <= '0;
			pixel_y_q   <= '0;
			in_tile_x_q <= '0;
			in_tile_y_q <= '0;
			tile_x_q    <= '0;
			tile_y_q    <= '0;
		end else if (adv) begin
			if (info.row_end) begin
				pixel_x_q   <= '0;
				in_tile_x_q <= '0;
				tile_x_q    <= '0;
				if (info.col_end) begin
					pixel_y_q   <= '0;
					in_tile_y_q <= '0;
					tile_y_q    <= '0;
				end else begin
					pixel_y_q <= pixel_y_q + POS_W'(1);
					if (info.ty_end) begin
						in_tile_y_q <= '0;
						tile_y_q    <= tile_y_q + POS_W'(1);
					end else begin
						in_tile_y_q <= in_tile_y_q + IN_TILE_W'(1);
					end
				end
			end else begin
				pixel_x_q <= pixel_x_q + POS_W'(1);
				if (info.tx_end) begin
					in_tile_x_q <= '0;
					tile_x_q    <= tile_x_q + POS_W'(1);
				end else begin
					in_tile_x_q <= in_tile_x_q + IN_TILE_W'(1);
				end
			end
		end
	end

endmodule

@@ sv/fdtd_flags.sv @@
// Per tile column dirty flags: flag memory, running segment flag and clearing pass.
`include "frame_dirty_tile_detector_top_defines.svh"

module fdtd_flags
	import fdtd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  logic      diff,
	input  pos_info_t info,
	output logic      ready,
	output logic      tile_dirty
);

	localparam logic [COL_AW-1:0] CLR_LAST = COL_AW'(MAX_WIDTH - 1);

	logic              seg_start_q;
	logic              fwd_sel_q;
	logic              fwd_val_q;
	logic              acc_q;
	logic              old_q;
	logic [ONES_W-1:0] ones_q;
	logic              clr_busy_q;
	logic [COL_AW-1:0] clr_ptr_q;

	logic              ram_rdata;
	logic              stored_now;
	logic              old_now;
	logic              acc_now;
	logic              wr;
	logic              wr_val;
	logic              fwd_hit;
	logic [ONES_W-1:0] ones_next;
	logic              ram_we;
	logic [COL_AW-1:0] ram_waddr;
	logic              ram_wdata;

	// The stored flag of a column is fetched when the previous segment ends;
	// it is taken from the write itself when the next column is the same one.
	assign stored_now = fwd_sel_q ? fwd_val_q : ram_rdata;
	assign old_now    = seg_start_q ? stored_now : old_q;
	assign acc_now    = (seg_start_q ? stored_now : acc_q) | diff;
	assign tile_dirty = acc_now;

	assign wr      = adv && info.tx_end;
	assign wr_val  = info.ty_end ? 1'b0 : acc_now;
	assign fwd_hit = info.done || (info.next_col == info.col);

	// Count of set entries in memory, so a frame end only sweeps when needed.
	always_comb begin
		ones_next = ones_q;
		if (wr && wr_val && !old_now) begin
			ones_next = ones_q + ONES_W'(1);
		end else if (wr && !wr_val && old_now) begin
			ones_next = ones_q - ONES_W'(1);
		end
	end

	assign ram_we    = clr_busy_q || wr;
	assign ram_waddr = clr_busy_q ? clr_ptr_q : info.col;
	assign ram_wdata = clr_busy_q ? 1'b0 : wr_val;
	assign ready     = !clr_busy_q;

	fdtd_ram #(
		.WIDTH(1),
		.DEPTH(MAX_WIDTH)
	) u_flag_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (wr && !fwd_hit),
		.raddr(info.next_col),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_start_q <= 1'b1;
			fwd_sel_q   <= 1'b1;
			fwd_val_q   <= 1'b0;
			acc_q       <= 1'b0;
			old_q       <= 1'b0;
			ones_q      <= '0;
			clr_busy_q  <= 1'b1;
			clr_ptr_q   <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_ptr_q <= clr_ptr_q + COL_AW'(1);
				if (clr_ptr_q == CLR_LAST) begin
					clr_busy_q <= 1'b0;
					ones_q     <= '0;
				end
			end else if (adv) begin
				ones_q <= ones_next;
				if (wr) begin
					seg_start_q <= 1'b1;
					fwd_sel_q   <= fwd_hit;
					fwd_val_q   <= info.done ? 1'b0 : wr_val;
				end else begin
					seg_start_q <= 1'b0;
					acc_q       <= acc_now;
					old_q       <= old_now;
				end
				if (info.done && (ones_next != '0)) begin
					clr_busy_q <= 1'b1;
					clr_ptr_q  <= '0;
				end
			end
		end
	end

	`FDTD_ASSERT_IMP(a_no_xfer_in_clear, clr_busy_q, !adv, "pixel transfer during flag clearing pass")
	`FDTD_ASSERT_NXT(a_clear_ends_empty, clr_busy_q && (clr_ptr_q == CLR_LAST), !clr_busy_q && (ones_q == '0), "flag clearing pass did not end with an empty count")
	`FDTD_ASSERT_IMP(a_ones_bounded, 1'b1, ones_q <= ONES_W'(MAX_WIDTH), "set flag count exceeds the number of columns")

endmodule

@@ sv/frame_dirty_tile_detector_top.sv @@
// A tile's result is registered on its last pixel pair. Throughput: one pixel pair per
// cycle unless a clearing pass or a waiting result holds it; the flag memory is read for
// the next tile column at the end of each segment, so consecutive transfers never wait
// on the read. Reset: all but the result registers take their defaults, then a clearing
// pass of the flag memory runs with in_ready low; a frame end leaving set flags repeats it.
module frame_dirty_tile_detector_top
	import fdtd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [PIX_W-1:0]   new_pixel,
	input  logic [PIX_W-1:0]   old_pixel,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [POS_W-1:0]   tile_column,
	output logic [POS_W-1:0]   tile_row,
	output logic               tile_dirty,
	output logic [COUNT_W-1:0] dirty_count,
	output logic               frame_done
);

	logic [CFG_DIM_W-1:0]  frame_width_q;
	logic [CFG_DIM_W-1:0]  frame_height_q;
	logic [CFG_TILE_W-1:0] tile_edge_q;
	logic [COUNT_W-1:0]    dirty_total_q;
	logic                  out_valid_q;
	logic [POS_W-1:0]      tile_column_q;
	logic [POS_W-1:0]      tile_row_q;
	logic                  tile_dirty_q;
	logic [COUNT_W-1:0]    dirty_count_q;
	logic                  frame_done_q;

	pos_info_t             info;
	logic                  flags_ready;
	logic                  cur_dirty;
	logic                  diff;
	logic                  adv;
	logic                  cfg_wr;
	cfg_reg_t              cfg_addr;
	logic [COUNT_W-1:0]    count_next;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign cfg_addr = cfg_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			tile_edge_q    <= TILE_EDGE_RST;
		end else if (cfg_wr) begin
			case (cfg_addr)
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[CFG_DIM_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[CFG_DIM_W-1:0];
				REG_TILE_EDGE:    tile_edge_q    <= pwdata[CFG_TILE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_addr)
			REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height_q);
			REG_TILE_EDGE:    prdata = APB_DW'(tile_edge_q);
			default:          prdata = '0;
		endcase
	end

	assign diff = ((new_pixel ^ old_pixel) & PIX_MASK) != '0;

	// A pixel that finishes no tile is taken even while a result waits.
	assign in_ready = flags_ready && (!info.emit || !out_valid_q || out_ready);
	assign adv      = in_valid && in_ready;

	fdtd_pos u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.frame_width (frame_width_q),
		.frame_height(frame_height_q),
		.tile_edge   (tile_edge_q),
		.info        (info)
	);

	fdtd_flags u_flags (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.diff      (diff),
		.info      (info),
		.ready     (flags_ready),
		.tile_dirty(cur_dirty)
	);

	assign count_next = dirty_total_q + COUNT_W'(cur_dirty);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_total_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (adv && info.emit) begin
				out_valid_q   <= 1'b1;
				dirty_total_q <= info.done ? '0 : count_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && info.emit) begin
			tile_column_q <= info.tile_x;
			tile_row_q    <= info.tile_y;
			tile_dirty_q  <= cur_dirty;
			dirty_count_q <= count_next;
			frame_done_q  <= info.done;
		end
	end

	assign out_valid   = out_valid_q;
	assign tile_column = tile_column_q;
	assign tile_row    = tile_row_q;
	assign tile_dirty  = tile_dirty_q;
	assign dirty_count = dirty_count_q;
	assign frame_done  = frame_done_q;

endmodule

@@ verif/fdtd_tile_checker.sv @@
// Scoreboard that predicts and checks the tile results of the frame dirty tile detector.
`timescale 1ns / 100ps
module fdtd_tile_checker
	import fdtd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	input  logic [APB_DW-1:0]  prdata,
	input  logic               pready,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [PIX_W-1:0]   new_pixel,
	input  logic [PIX_W-1:0]   old_pixel,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [POS_W-1:0]   tile_column,
	input  logic [POS_W-1:0]   tile_row,
	input  logic               tile_dirty,
	input  logic [COUNT_W-1:0] dirty_count,
	input  logic               frame_done,
	output int unsigned        mismatches,
	output int unsigned        tiles_pending
);

	typedef struct {
		logic [POS_W-1:0]   column;
		logic [POS_W-1:0]   row;
		logic               dirty;
		logic [COUNT_W-1:0] count;
		logic               done;
	} tile_result_t;

	logic [CFG_DIM_W-1:0]  frame_width;
	logic [CFG_DIM_W-1:0]  frame_height;
	logic [CFG_TILE_W-1:0] tile_edge;

	logic [POS_W-1:0]     pixel_x;
	logic [POS_W-1:0]     pixel_y;
	logic [IN_TILE_W-1:0] in_tile_x;
	logic [IN_TILE_W-1:0] in_tile_y;
	logic [POS_W-1:0]     tile_x;
	logic [POS_W-1:0]     tile_y;
	logic                 column_dirty [MAX_WIDTH];
	logic [COUNT_W-1:0]   frame_dirty_sum;

	tile_result_t expected_tiles [$];
	int unsigned  fails = 0;
	int unsigned  pending = 0;

	assign mismatches    = fails;
	assign tiles_pending = pending;

	// A zero setting behaves as one, an oversized one as the limit.
	function automatic int limit_size(input int v, input int hi);
		if (v == 0) begin
			return 1;
		end
		return (v > hi) ? hi : v;
	endfunction

	task automatic note_failure(input string msg);
		if (fails < 10) begin
			$display("%s", msg);
		end
		fails++;
	endtask

	task automatic clear_frame_state();
		pixel_x   = '0;
		pixel_y   = '0;
		in_tile_x = '0;
		in_tile_y = '0;
		tile_x    = '0;
		tile_y    = '0;
		foreach (column_dirty[i]) begin
			column_dirty[i] = 1'b0;
		end
		frame_dirty_sum = '0;
	endtask

	task automatic scan_pixel_pair(input logic [PIX_W-1:0] fresh, input logic [PIX_W-1:0] prior);
		int           w;
		int           h;
		int           ts;
		logic         differ;
		logic         row_end;
		logic         col_end;
		logic         tx_end;
		logic         ty_end;
		logic         done;
		tile_result_t tile;
		w  = limit_size(int'(frame_width), MAX_WIDTH);
		h  = limit_size(int'(frame_height), MAX_HEIGHT);
		ts = limit_size(int'(tile_edge), TILE_LIMIT);
		differ = ((fresh ^ prior) & PIX_MASK) != '0;
		// Counters left beyond a shrunken frame or tile end their span on this pixel.
		row_end = int'(pixel_x) >= w - 1;
		col_end = int'(pixel_y) >= h - 1;
		tx_end  = row_end || int'(in_tile_x) >= ts - 1;
		ty_end  = col_end || int'(in_tile_y) >= ts - 1;

		if (differ) begin
			column_dirty[tile_x] = 1'b1;
		end
		if (tx_end && ty_end) begin
			done            = row_end && col_end;
			frame_dirty_sum = frame_dirty_sum + COUNT_W'(column_dirty[tile_x]);
			tile.column     = tile_x;
			tile.row        = tile_y;
			tile.dirty      = column_dirty[tile_x];
			tile.count      = frame_dirty_sum;
			tile.done       = done;
			expected_tiles.insert(expected_tiles.size(), tile);
			column_dirty[tile_x] = 1'b0;
			if (done) begin
				clear_frame_state();
				return;
			end
		end

		if (row_end) begin
			pixel_x   = '0;
			in_tile_x = '0;
			tile_x    = '0;
			if (col_end) begin
				pixel_y   = '0;
				in_tile_y = '0;
				tile_y    = '0;
			end else begin
				pixel_y++;
				if (ty_end) begin
					in_tile_y = '0;
					tile_y++;
				end else begin
					in_tile_y++;
				end
			end
		end else begin
			pixel_x++;
			if (tx_end) begin
				in_tile_x = '0;
				tile_x++;
			end else begin
				in_tile_x++;
			end
		end
	endtask

	task automatic check_tile();
		tile_result_t want;
		if (expected_tiles.size() == 0) begin
			note_failure($sformatf("unexpected tile transfer: col %0d row %0d dirty %0b count %0d done %0b",
				tile_column, tile_row, tile_dirty, dirty_count, frame_done));
			return;
		end
		want = expected_tiles.pop_front();
		if (tile_column !== want.column || tile_row !== want.row || tile_dirty !== want.dirty ||
				dirty_count !== want.count || frame_done !== want.done) begin
			note_failure($sformatf({"tile mismatch: expected col %0d row %0d dirty %0b count %0d",
				" done %0b, got col %0d row %0d dirty %0b count %0d done %0b"},
				want.column, want.row, want.dirty, want.count, want.done,
				tile_column, tile_row, tile_dirty, dirty_count, frame_done));
		end
	endtask

	task automatic access_register();
		logic [APB_DW-1:0] want;
		case (cfg_reg_t'(paddr[APB_AW-1:2]))
			REG_FRAME_WIDTH: begin
				if (pwrite) frame_width = pwdata[CFG_DIM_W-1:0];
				want = APB_DW'(frame_width);
			end
			REG_FRAME_HEIGHT: begin
				if (pwrite) frame_height = pwdata[CFG_DIM_W-1:0];
				want = APB_DW'(frame_height);
			end
			REG_TILE_EDGE: begin
				if (pwrite) tile_edge = pwdata[CFG_TILE_W-1:0];
				want = APB_DW'(tile_edge);
			end
			default: return;
		endcase
		if (!pwrite && prdata !== want) begin
			note_failure($sformatf("register read mismatch at 0x%0h: expected 0x%0h, got 0x%0h",
				paddr, want, prdata));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width  = FRAME_WIDTH_RST;
			frame_height = FRAME_HEIGHT_RST;
			tile_edge    = TILE_EDGE_RST;
			clear_frame_state();
			expected_tiles.delete();
		end else begin
			if (psel && penable && pready) begin
				access_register();
			end
			// A tile result always trails its last pixel, so results are matched first.
			if (out_valid && out_ready) begin
				check_tile();
			end
			if (in_valid && in_ready) begin
				scan_pixel_pair(new_pixel, old_pixel);
			end
		end
		pending = expected_tiles.size();
	end

endmodule

@@ verif/tb_top.sv @@
// Top of the frame dirty tile detector testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
	import fdtd_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_PIXELS  = 1025;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [APB_AW-1:0]  paddr;
	logic [APB_DW-1:0]  pwdata;
	logic [APB_DW-1:0]  prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic [PIX_W-1:0]   new_pixel;
	logic [PIX_W-1:0]   old_pixel;
	logic               out_valid;
	logic               out_ready;
	logic [POS_W-1:0]   tile_column;
	logic [POS_W-1:0]   tile_row;
	logic               tile_dirty;
	logic [COUNT_W-1:0] dirty_count;
	logic               frame_done;

	int unsigned mismatches;
	int unsigned tiles_pending;
	bit          tx_pace = 1'b0;
	bit          rx_pace = 1'b0;
	int          idle_cycles = 0;

	frame_dirty_tile_detector_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .new_pixel(new_pixel), .old_pixel(old_pixel),
		.out_valid(out_valid), .out_ready(out_ready), .tile_column(tile_column),
		.tile_row(tile_row), .tile_dirty(tile_dirty), .dirty_count(dirty_count),
		.frame_done(frame_done)
	);

	fdtd_tile_checker tile_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .new_pixel(new_pixel), .old_pixel(old_pixel),
		.out_valid(out_valid), .out_ready(out_ready), .tile_column(tile_column),
		.tile_row(tile_row), .tile_dirty(tile_dirty), .dirty_count(dirty_count),
		.frame_done(frame_done),
		.mismatches(mismatches), .tiles_pending(tiles_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The clearing pass after a frame end with set flags holds in_ready low.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result side: after each transfer, out_ready may drop for a random stall if rx_pace is set.
	initial begin
		int stall;
		stall = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				stall = rx_pace ? $urandom_range(0, 12) : 0;
			end
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer with in_valid
	// still high, so a following pixel pair can be presented without a gap.
	task automatic send_pair(input logic [PIX_W-1:0] fresh, input logic [PIX_W-1:0] prior);
		int gap;
		gap = tx_pace ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		new_pixel <= fresh;
		old_pixel <= prior;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_random_pair(input int rate);
		logic [PIX_W-1:0] prior;
		logic [PIX_W-1:0] fresh;
		case ($urandom_range(0, 9))
			0: prior = '0;
			1: prior = '1;
			default: prior = PIX_W'($urandom());
		endcase
		fresh = prior;
		if ($urandom_range(0, 99) < rate) begin
			case ($urandom_range(0, 2))
				0: fresh = prior ^ (PIX_W'(1) << $urandom_range(0, PIX_W - 1));
				1: fresh = ~prior;
				default: fresh = prior ^ PIX_W'($urandom_range(1, (1 << PIX_W) - 1));
			endcase
		end
		send_pair(fresh, prior);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (tiles_pending != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic apb_transfer(input cfg_reg_t idx, input bit is_write, input int unsigned value);
		logic [APB_DW-1:0] field_mask;
		field_mask = (idx == REG_TILE_EDGE) ? APB_DW'((1 << CFG_TILE_W) - 1) :
			APB_DW'((1 << CFG_DIM_W) - 1);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= {idx, 2'b00};
		// Bits above the register field carry noise; the register ignores them.
		pwdata  <= (APB_DW'(value) & field_mask) | ($urandom() & ~field_mask);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input int unsigned w, input int unsigned h, input int unsigned ts);
		wait_idle();
		apb_transfer(REG_FRAME_WIDTH, 1'b1, w);
		apb_transfer(REG_FRAME_HEIGHT, 1'b1, h);
		apb_transfer(REG_TILE_EDGE, 1'b1, ts);
		apb_transfer(REG_FRAME_WIDTH, 1'b0, 0);
		apb_transfer(REG_FRAME_HEIGHT, 1'b0, 0);
		apb_transfer(REG_TILE_EDGE, 1'b0, 0);
	endtask

	initial begin
		int sent;
		int phase;
		int count;
		int area;
		int rate;
		int w;
		int h;
		int ts;
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		in_valid  = 1'b0;
		new_pixel = '0;
		old_pixel = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Default geometry: a few pixels into the first tile, one of them differing.
		send_pair(16'h0000, 16'h0000);
		send_pair(16'hFFFF, 16'hFFFF);
		send_pair(16'h0001, 16'h0000);

		// Zero sizes act as one; the column counter is already past the new row end,
		// so the next pixel closes the frame and reports the flag left behind.
		configure(0, 0, 0);
		send_pair(16'hFFFF, 16'hFFFF);
		send_pair(16'h8000, 16'h0000);
		send_pair(16'h1234, 16'h1234);

		// Clipped right tile column, with only the corner pixel differing.
		configure(3, 2, 2);
		repeat (5) send_pair(16'h5555, 16'h5555);
		send_pair(16'h0000, 16'h8000);

		// Shrink the frame and tile in the middle of a row.
		configure(7, 3, 5);
		send_pair(16'hAAAA, 16'hAAAA);
		send_pair(16'h00FF, 16'hFF00);
		repeat (2) send_pair(16'hAAAA, 16'hAAAA);
		configure(3, 3, 2);
		repeat (6) send_pair(16'h7E7E, 16'h7E7E);
		send_pair(16'hFFFF, 16'h7FFF);

		// Tile larger than the frame: a single tile.
		configure(2, 2, 9);
		send_pair(16'h0F0F, 16'h0F0F);
		send_pair(16'h0F0F, 16'h0F0E);
		repeat (2) send_pair(16'h0F0F, 16'h0F0F);

		sent  = 0;
		phase = 0;
		while (sent < RANDOM_PIXELS) begin
			case (phase)
				0: begin
					// Oversized width and tile clamp to the limits: one full 512-pixel row.
					w = 1023;
					h = 1;
					ts = 127;
					count = 512;
				end
				1: begin
					// Tall column left unfinished; the next geometry cuts it short.
					w = 1;
					h = 1023;
					ts = 64;
					count = $urandom_range(80, 140);
				end
				default: begin
					case ($urandom_range(0, 9))
						0: begin
							w = $urandom_range(0, 6);
							h = $urandom_range(0, 6);
							ts = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
						end
						1: begin
							w = $urandom_range(1, 40);
							h = $urandom_range(1, 3);
							ts = $urandom_range(1, 64);
						end
						default: begin
							w = $urandom_range(1, 16);
							h = $urandom_range(1, 10);
							ts = $urandom_range(1, 6);
						end
					endcase
					area = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
					count = ($urandom_range(0, 3) != 0) ? area * $urandom_range(1, 3) :
						$urandom_range(1, 40);
					if (count > 300) begin
						count = 300;
					end
				end
			endcase
			if (count > RANDOM_PIXELS - sent) begin
				count = RANDOM_PIXELS - sent;
			end
			configure(w, h, ts);
			tx_pace = $urandom_range(0, 3) != 0;
			rx_pace = $urandom_range(0, 3) != 0;
			case ($urandom_range(0, 4))
				0: rate = 0;
				1: rate = 1;
				2: rate = 5;
				3: rate = 30;
				default: rate = 100;
			endcase
			repeat (count) begin
				if ($urandom_range(0, 199) == 0) begin
					wait_idle();
				end
				send_random_pair(rate);
			end
			sent += count;
			phase++;
		end

		wait_idle();
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
